/* src/rcpa_pkg.sv */
// ----------------------------------------------------------------------------
// rcpa_pkg: shared types and constants of the page allocator
// Word formats, operation and status codes, and sizes of the page tables.
// ----------------------------------------------------------------------------
package rcpa_pkg;

	localparam int NUM_PAGES = 32768;
	localparam int PAGE_BITS = 12;

	localparam int ADDR_W  = 32;
	localparam int PG_W    = $clog2(NUM_PAGES);
	localparam int FT_W    = $clog2(NUM_PAGES + 1);
	localparam int VPG_W   = ADDR_W - PAGE_BITS;
	localparam int CNT_W   = 16;
	localparam int LOW_W   = 15;
	localparam int ALLOC_W = 27;

	// Depth of the two small queues (command and result).
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] FN_ALLOC  = 2'd0;
	localparam logic [1:0] FN_FREE   = 2'd1;
	localparam logic [1:0] FN_ADDREF = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_BADADDR = 3'd2;
	localparam logic [2:0] ST_REFERR  = 3'd3;
	localparam logic [2:0] ST_ISFREE  = 3'd4;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic [1:0]        func;
		logic [ADDR_W-1:0] page_addr;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [ALLOC_W-1:0] alloc_addr;
		logic [CNT_W-1:0]   count_after;
		logic               released;
	} rsp_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_ALLOC,
		OP_FREE,
		OP_ADDREF,
		OP_BAD
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [PG_W-1:0] page;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_EXEC
	} back_state_t;

endpackage

/* src/rcpa_ram.sv */
// ----------------------------------------------------------------------------
// rcpa_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module rcpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/rcpa_front.sv */
// ----------------------------------------------------------------------------
// rcpa_front: request intake and classification
// Decodes each request word, checks the page address and queues a command.
// ----------------------------------------------------------------------------
module rcpa_front import rcpa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [LOW_W-1:0] low_page,
	input  logic             push,
	output logic             full,
	input  req_t             req,
	output logic             cmd_valid,
	input  logic             cmd_pop,
	output cmd_t             cmd
);

	logic [VPG_W-1:0] vpage;
	logic             aligned;
	logic             in_range;
	logic             above_low;
	cmd_t             cmd_in;
	logic             push_ok;

	cmd_t             ent_q [Q_DEPTH];
	logic [Q_AW-1:0]  wp_q;
	logic [Q_AW-1:0]  rp_q;
	logic [Q_CW-1:0]  cnt_q;

	assign vpage     = req.page_addr[ADDR_W-1:PAGE_BITS];
	assign aligned   = (req.page_addr[PAGE_BITS-1:0] == '0);
	assign in_range  = (vpage < VPG_W'(NUM_PAGES));
	assign above_low = (vpage >= VPG_W'(low_page));

	always_comb begin
		cmd_in.page = PG_W'(vpage);
		case (req.func)
			FN_ALLOC: begin
				cmd_in.op = OP_ALLOC;
			end
			FN_FREE: begin
				cmd_in.op = (aligned && in_range && above_low) ? OP_FREE : OP_BAD;
			end
			FN_ADDREF: begin
				// The page holding the address is used; no alignment check here.
				cmd_in.op = in_range ? OP_ADDREF : OP_BAD;
			end
			default: begin
				cmd_in.op = OP_NOP;
			end
		endcase
	end

	assign full      = (cnt_q == Q_CW'(Q_DEPTH));
	assign push_ok   = push && !full;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wp_q <= wp_q + Q_AW'(1);
			end
			if (cmd_pop) begin
				rp_q <= rp_q + Q_AW'(1);
			end
			case ({push_ok, cmd_pop})
				2'b10: cnt_q <= cnt_q + Q_CW'(1);
				2'b01: cnt_q <= cnt_q - Q_CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			ent_q[wp_q] <= cmd_in;
		end
	end

endmodule

/* src/rcpa_back.sv */
// ----------------------------------------------------------------------------
// rcpa_back: command execution
// Reads the count and stack memories, updates them and queues the response.
// ----------------------------------------------------------------------------
module rcpa_back import rcpa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [LOW_W-1:0] low_page,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	input  cmd_t             cmd,
	output logic             empty,
	input  logic             pop,
	output rsp_t             rsp
);

	back_state_t state_q;
	back_state_t state_d;
	cmd_t        cmd_s1;
	logic        start;

	logic [FT_W-1:0]  depth_q;
	logic [FT_W-1:0]  depth_d;
	logic [FT_W-1:0]  fresh_q;
	logic [FT_W-1:0]  fresh_d;

	logic             cnt_we;
	logic [PG_W-1:0]  cnt_waddr;
	logic [CNT_W-1:0] cnt_wdata;
	logic [CNT_W-1:0] cnt_rdata;
	logic             stk_we;
	logic [PG_W-1:0]  stk_waddr;
	logic [PG_W-1:0]  stk_raddr;
	logic [PG_W-1:0]  stk_rdata;

	logic [CNT_W-1:0] cnt_cur;
	logic [CNT_W-1:0] cnt_dec;
	logic [CNT_W-1:0] cnt_inc;
	logic [PG_W-1:0]  alloc_pg;

	logic             rsp_push;
	rsp_t             rsp_word;
	rsp_t             rq_q [Q_DEPTH];
	logic [Q_AW-1:0]  rwp_q;
	logic [Q_AW-1:0]  rrp_q;
	logic [Q_CW-1:0]  rcnt_q;
	logic             rsp_pop;
	logic             rsp_full;

	rcpa_ram #(.WIDTH(CNT_W), .DEPTH(NUM_PAGES)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cmd.page),
		.rdata (cnt_rdata)
	);

	rcpa_ram #(.WIDTH(PG_W), .DEPTH(NUM_PAGES)) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (cmd_s1.page),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign stk_raddr = PG_W'(depth_q - FT_W'(1));
	assign start     = (state_q == BK_IDLE) && cmd_valid && !rsp_full;

	// Every page at or above the fresh boundary has been handed out once, so its
	// count entry has been written; entries below it still read as zero.
	assign cnt_cur = (FT_W'(cmd_s1.page) >= fresh_q) ? cnt_rdata : '0;
	assign cnt_dec = cnt_cur - CNT_W'(1);
	assign cnt_inc = cnt_cur + CNT_W'(1);

	always_comb begin
		case (state_q)
			BK_IDLE: state_d = start ? BK_EXEC : BK_IDLE;
			BK_EXEC: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		cnt_we    = 1'b0;
		cnt_waddr = cmd_s1.page;
		cnt_wdata = '0;
		stk_we    = 1'b0;
		stk_waddr = PG_W'(depth_q);
		rsp_push  = 1'b0;
		rsp_word  = '0;
		depth_d   = depth_q;
		fresh_d   = fresh_q;
		alloc_pg  = stk_rdata;
		case (state_q)
			BK_IDLE: begin
				cmd_pop = start;
			end
			BK_EXEC: begin
				rsp_push = 1'b1;
				case (cmd_s1.op)
					OP_ALLOC: begin
						if (depth_q != '0) begin
							depth_d  = depth_q - FT_W'(1);
							alloc_pg = stk_rdata;
						end else if (fresh_q > FT_W'(low_page) && fresh_q != '0) begin
							fresh_d  = fresh_q - FT_W'(1);
							alloc_pg = PG_W'(fresh_q - FT_W'(1));
						end
						if (depth_q != '0 || (fresh_q > FT_W'(low_page) && fresh_q != '0))
						begin
							cnt_we               = 1'b1;
							cnt_waddr            = alloc_pg;
							cnt_wdata            = CNT_W'(1);
							rsp_word.status      = ST_OK;
							rsp_word.alloc_addr  = ALLOC_W'({alloc_pg, PAGE_BITS'(0)});
							rsp_word.count_after = CNT_W'(1);
						end else begin
							rsp_word.status = ST_EMPTY;
						end
					end
					OP_FREE: begin
						if (cnt_cur == '0) begin
							rsp_word.status = ST_ISFREE;
						end else begin
							cnt_we          = 1'b1;
							cnt_wdata       = cnt_dec;
							rsp_word.status = ST_OK;
							if (cnt_dec == '0) begin
								rsp_word.released = 1'b1;
								// A push onto a full stack is dropped.
								if (depth_q < FT_W'(NUM_PAGES)) begin
									stk_we  = 1'b1;
									depth_d = depth_q + FT_W'(1);
								end
							end else begin
								rsp_word.count_after = cnt_dec;
							end
						end
					end
					OP_ADDREF: begin
						if (cnt_cur == '0 || cnt_cur == CNT_MAX) begin
							rsp_word.status      = ST_REFERR;
							rsp_word.count_after = cnt_cur;
						end else begin
							cnt_we               = 1'b1;
							cnt_wdata            = cnt_inc;
							rsp_word.status      = ST_OK;
							rsp_word.count_after = cnt_inc;
						end
					end
					OP_BAD: begin
						rsp_word.status = ST_BADADDR;
					end
					default: begin
						rsp_word = '0;
					end
				endcase
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			depth_q <= '0;
			fresh_q <= FT_W'(NUM_PAGES);
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			fresh_q <= fresh_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_s1 <= cmd;
		end
	end

	// Result queue: the back waits in idle while it is full.
	assign empty    = (rcnt_q == '0);
	assign rsp_full = (rcnt_q == Q_CW'(Q_DEPTH));
	assign rsp_pop  = pop && !empty;
	assign rsp      = rq_q[rrp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rwp_q  <= '0;
			rrp_q  <= '0;
			rcnt_q <= '0;
		end else begin
			if (rsp_push) begin
				rwp_q <= rwp_q + Q_AW'(1);
			end
			if (rsp_pop) begin
				rrp_q <= rrp_q + Q_AW'(1);
			end
			case ({rsp_push, rsp_pop})
				2'b10: rcnt_q <= rcnt_q + Q_CW'(1);
				2'b01: rcnt_q <= rcnt_q - Q_CW'(1);
				default: rcnt_q <= rcnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_push) begin
			rq_q[rwp_q] <= rsp_word;
		end
	end

endmodule

/* src/refcounted_page_allocator.sv */
// ----------------------------------------------------------------------------
// refcounted_page_allocator: page-frame allocator with reference counts
// Requests are pushed like into a queue: a word is taken when push is high
// and full is low. A word is an allocate, free, add-reference or no-op.
// Responses are read like from a queue: while empty is low the oldest
// response word is on rsp, and pop takes it. Every request yields exactly
// one response, in request order.
// A request waits in the command queue until the idle back takes it; the
// back queues its response before it takes the next command. The count
// memory is read in one cycle and written in the next.
// cfg_we writes low_page; write it only while no request is outstanding.
// After reset the stack of freed pages is empty, the fresh-page boundary is
// at the top of the page range, and all counts read as zero; there is no
// clearing pass, so requests are taken right away.
// When the receiver stops popping, two response words are held, then two
// more requests queue up in front, and full rises until pop resumes.
// ----------------------------------------------------------------------------
module refcounted_page_allocator import rcpa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LOW_W-1:0] cfg_wdata,
	input  logic             push,
	output logic             full,
	input  req_t             req,
	output logic             empty,
	input  logic             pop,
	output rsp_t             rsp
);

	logic [LOW_W-1:0] low_page_q;
	logic             cmd_valid;
	logic             cmd_pop;
	cmd_t             cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_page_q <= '0;
		end else if (cfg_we) begin
			low_page_q <= cfg_wdata;
		end
	end

	rcpa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.low_page  (low_page_q),
		.push      (push),
		.full      (full),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	rcpa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.low_page  (low_page_q),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp)
	);

endmodule

/* test/page_alloc_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_alloc_checker: response checker for the page allocator
// Watches the request, response and register channels. Each accepted
// request is run through a local model of the page tables, and every
// response word that is popped is compared field by field with the oldest
// predicted word.
// ----------------------------------------------------------------------------
module page_alloc_checker import rcpa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LOW_W-1:0] cfg_wdata,
	input  logic             push,
	input  logic             full,
	input  req_t             req,
	input  logic             empty,
	input  logic             pop,
	input  rsp_t             rsp,
	output int               outstanding,
	output int               mismatches
);

	localparam int SHOWN = 10;

	logic [CNT_W-1:0] page_refs [NUM_PAGES];
	logic [PG_W-1:0]  freed_pages [NUM_PAGES];
	int unsigned      freed_depth;
	int unsigned      fresh_bound;
	int unsigned      low_bound;
	rsp_t             predicted_rsps [$];

	function automatic rsp_t apply_page_op(input req_t w);
		rsp_t             r;
		logic [VPG_W-1:0] vpg;
		logic [PG_W-1:0]  pg;
		logic [CNT_W-1:0] cnt;
		r = '0;
		vpg = w.page_addr[ADDR_W-1:PAGE_BITS];
		pg = vpg[PG_W-1:0];
		case (w.func)
			FN_ALLOC: begin
				// Recycled pages go first; the fresh boundary only falls.
				if (freed_depth > 0) begin
					freed_depth--;
					pg = freed_pages[freed_depth];
				end else if (fresh_bound > low_bound) begin
					fresh_bound--;
					pg = PG_W'(fresh_bound);
				end else begin
					r.status = ST_EMPTY;
					return r;
				end
				page_refs[pg] = CNT_W'(1);
				r.alloc_addr = ALLOC_W'(pg) << PAGE_BITS;
				r.count_after = CNT_W'(1);
			end
			FN_FREE: begin
				if (w.page_addr[PAGE_BITS-1:0] != '0 || vpg < low_bound || vpg >= NUM_PAGES) begin
					r.status = ST_BADADDR;
				end else if (page_refs[pg] == '0) begin
					r.status = ST_ISFREE;
				end else begin
					cnt = page_refs[pg] - 1'b1;
					page_refs[pg] = cnt;
					if (cnt == '0) begin
						if (freed_depth < NUM_PAGES) begin
							freed_pages[freed_depth] = pg;
							freed_depth++;
						end
						r.released = 1'b1;
					end else begin
						r.count_after = cnt;
					end
				end
			end
			FN_ADDREF: begin
				if (vpg >= NUM_PAGES) begin
					r.status = ST_BADADDR;
				end else begin
					cnt = page_refs[pg];
					if (cnt == '0 || cnt == CNT_MAX) begin
						r.status = ST_REFERR;
						r.count_after = cnt;
					end else begin
						cnt++;
						page_refs[pg] = cnt;
						r.count_after = cnt;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
		mismatches++;
		if (mismatches <= SHOWN)
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			foreach (page_refs[i])
				page_refs[i] = '0;
			freed_depth = 0;
			fresh_bound = NUM_PAGES;
			low_bound = 0;
			predicted_rsps.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (pop && !empty) begin
				if (predicted_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOWN)
						$display("%0t: response word with nothing pending, status %0d",
							$time, rsp.status);
				end else begin
					want = predicted_rsps.pop_front();
					if (rsp.status !== want.status)
						flag("status", want.status, rsp.status);
					if (rsp.alloc_addr !== want.alloc_addr)
						flag("alloc_addr", want.alloc_addr, rsp.alloc_addr);
					if (rsp.count_after !== want.count_after)
						flag("count_after", want.count_after, rsp.count_after);
					if (rsp.released !== want.released)
						flag("released", want.released, rsp.released);
				end
			end
			if (push && !full)
				predicted_rsps.push_back(apply_page_op(req));
			if (cfg_we)
				low_bound = 32'(cfg_wdata);
			outstanding <= predicted_rsps.size();
		end
	end

endmodule

/* test/refcounted_page_allocator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// refcounted_page_allocator_test: regression for the page allocator
// Runs a directed pass over the edge cases of allocate, free and
// add-reference, then runs random operations on pages recently handed out
// under several pacing and low_page settings. Checking is done by
// page_alloc_checker.
// ----------------------------------------------------------------------------
module refcounted_page_allocator_test;
	import rcpa_pkg::*;

	localparam logic [1:0]        FN_SPARE    = 2'd3;
	localparam logic [LOW_W-1:0]  LOW_MAX     = '1;
	localparam logic [ADDR_W-1:0] TOP_ADDR    = ADDR_W'(NUM_PAGES - 1) << PAGE_BITS;
	localparam logic [ADDR_W-1:0] PAST_END    = ADDR_W'(NUM_PAGES) << PAGE_BITS;
	localparam int                SETTLE      = 4;
	localparam int                STALL_LIMIT = 2000;
	localparam int                PHASE_ITEMS = 100;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [LOW_W-1:0] cfg_wdata = '0;
	logic             push = 1'b0;
	logic             full;
	req_t             req = '0;
	logic             empty;
	logic             pop = 1'b0;
	rsp_t             rsp;

	int              outstanding;
	int              mismatches;
	int              send_idle_pct = 0;
	int              recv_stall_pct = 0;
	int              quiet_cycles = 0;
	logic [PG_W-1:0] live_pages [$];

	always #4 clk = ~clk;

	refcounted_page_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.req       (req),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp)
	);

	page_alloc_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.push        (push),
		.full        (full),
		.req         (req),
		.empty       (empty),
		.pop         (pop),
		.rsp         (rsp),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Pages handed out are remembered so that frees and add-references hit
	// live pages most of the time. Sampled mid-cycle, ahead of the edge
	// that takes the word.
	always @(negedge clk) begin
		if (arst_n && pop && !empty && rsp.status == ST_OK && rsp.alloc_addr != '0) begin
			live_pages.push_back(rsp.alloc_addr[ALLOC_W-1:PAGE_BITS]);
			if (live_pages.size() > 48)
				void'(live_pages.pop_front());
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_word(input logic [1:0] fn, input logic [ADDR_W-1:0] addr);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		req <= '{func: fn, page_addr: addr};
		do @(posedge clk); while (full);
	endtask

	// Stops sending and waits until every response word has been taken.
	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_low_page(input logic [LOW_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [PG_W-1:0] pick_live_page();
		if (live_pages.size() == 0)
			return PG_W'($urandom_range(NUM_PAGES - 1));
		return live_pages[$urandom_range(live_pages.size() - 1)];
	endfunction

	task automatic send_random_op();
		int unsigned       pick;
		logic [ADDR_W-1:0] addr;
		pick = $urandom_range(99);
		addr = ADDR_W'(pick_live_page()) << PAGE_BITS;
		if (pick < 40) begin
			send_word(FN_ALLOC, $urandom());
		end else if (pick < 70) begin
			if ($urandom_range(9) == 0)
				addr[PAGE_BITS-1:0] = PAGE_BITS'($urandom_range(1, 2**PAGE_BITS - 1));
			send_word(FN_FREE, addr);
		end else if (pick < 92) begin
			addr[PAGE_BITS-1:0] = PAGE_BITS'($urandom());
			send_word(FN_ADDREF, addr);
		end else begin
			send_word(2'($urandom_range(3)), $urandom());
		end
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct,
			input logic [LOW_W-1:0] low);
		write_low_page(low);
		send_idle_pct <= send_pct;
		recv_stall_pct <= recv_pct;
		repeat (PHASE_ITEMS) send_random_op();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Only the top page may be handed out, so the pool runs dry at once.
		write_low_page(LOW_MAX);
		send_word(FN_ALLOC, '0);
		send_word(FN_ALLOC, '1);
		send_word(FN_ADDREF, TOP_ADDR);
		send_word(FN_ADDREF, TOP_ADDR | 32'hFFF);
		send_word(FN_FREE, TOP_ADDR | 32'h1);
		send_word(FN_FREE, TOP_ADDR);
		send_word(FN_FREE, TOP_ADDR);
		send_word(FN_FREE, TOP_ADDR);
		send_word(FN_FREE, TOP_ADDR);
		send_word(FN_ADDREF, TOP_ADDR);
		send_word(FN_ALLOC, '0);
		send_word(FN_FREE, '0);
		send_word(FN_FREE, 32'hFFFF_F000);
		send_word(FN_ADDREF, 32'hFFFF_FFFF);
		send_word(FN_ADDREF, PAST_END);
		send_word(FN_SPARE, 32'hFFFF_FFFF);
		send_word(FN_SPARE, '0);
		send_word(FN_FREE, TOP_ADDR);

		write_low_page('0);
		send_word(FN_ALLOC, '0);
		send_word(FN_ALLOC, '0);
		send_word(FN_FREE, '0);
		send_word(FN_ADDREF, '0);
		send_word(FN_FREE, PAST_END);

		run_phase(0, 0, '0);
		run_phase(72, 0, LOW_W'($urandom_range(1, 30000)));
		run_phase(0, 72, LOW_W'(NUM_PAGES - 64));
		run_phase(7, 7, '0);

		drain();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
